// ===== rtl/pcl_pkg.sv =====
// Package for the periodic cell list neighbor search unit.
// Holds sizes, command and status codes, the sequencer states and shared structs.
// No dependencies.
package pcl_pkg;

  localparam int COORD_BITS    = 24;
  localparam int DIST_BITS     = 2 * COORD_BITS;
  localparam int MAX_PARTICLES = 64;
  localparam int PART_BITS     = 6;
  localparam int CNT_BITS      = 7;
  localparam int CELL_SLOTS    = 64;
  localparam int CELL_BITS     = 6;
  localparam int MAX_CELLS     = 4;
  localparam int ITER_STEPS    = COORD_BITS;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_OCCUPY = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] REG_BOX   = 2'd0;
  localparam logic [1:0] REG_CELLS = 2'd1;
  localparam logic [1:0] REG_EDGE  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_OCC_HEAD, S_OCC_LINK, S_WB_GO, S_WB_WAIT, S_WE_GO, S_WE_WAIT,
    S_CELL, S_INS_WR, S_R2, S_SCAN, S_HEAD, S_PART, S_DM_GO, S_DM_WAIT,
    S_DMUL, S_DACC, S_DCMP, S_SQ_GO, S_SQ_WAIT, S_PUSH, S_NEXTP, S_FLUSH, S_EMIT
  } st_t;

  typedef enum logic {OP_DIV, OP_SQRT} iter_op_t;

  typedef struct packed {
    logic                 start;
    iter_op_t             op;
    logic [DIST_BITS-1:0] opa;
    logic [COORD_BITS:0]  dvs;
  } iter_req_t;

  typedef struct packed {
    logic                  done;
    logic [COORD_BITS-1:0] quo;
    logic [COORD_BITS-1:0] rem;
  } iter_rsp_t;

  typedef struct packed {
    logic [PART_BITS-1:0]  particle;
    logic [CELL_BITS-1:0]  cell_id;
    logic [CNT_BITS-1:0]   occupancy;
    logic [COORD_BITS-1:0] distance;
    logic                  found;
    logic [1:0]            status;
    logic                  last;
  } res_t;

endpackage

// ===== rtl/pcl_iter.sv =====
// Shared iterative unit: restoring divider (quotient and remainder) and
// integer square root, one bit of result per cycle. Depends on pcl_pkg.
module pcl_iter import pcl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  localparam int W = DIST_BITS + 1;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  iter_op_t             op_r, op_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [DIST_BITS-1:0] acc_r, acc_nxt;
  logic [DIST_BITS-1:0] aux_r, aux_nxt;
  logic [DIST_BITS-1:0] bit_r, bit_nxt;
  logic [COORD_BITS:0]  dvs_r, dvs_nxt;
  logic [W-1:0]         pa, pb;
  logic [W:0]           diff;
  logic                 ge;

  always_comb begin
    if (op_r == OP_DIV) begin
      pa = {{(W-COORD_BITS-2){1'b0}}, acc_r[COORD_BITS:0], aux_r[COORD_BITS-1]};
      pb = {{(W-COORD_BITS-1){1'b0}}, dvs_r};
    end else begin
      pa = {1'b0, acc_r};
      pb = {1'b0, aux_r} + {1'b0, bit_r};
    end
    diff = {1'b0, pa} - {1'b0, pb};
    ge   = ~diff[W];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    aux_nxt  = aux_r;
    bit_nxt  = bit_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      if (req.op == OP_DIV) begin
        acc_nxt = '0;
        aux_nxt = {{(DIST_BITS-COORD_BITS){1'b0}}, req.opa[COORD_BITS-1:0]};
        dvs_nxt = req.dvs;
      end else begin
        acc_nxt = req.opa;
        aux_nxt = '0;
        bit_nxt = {2'b01, {(DIST_BITS-2){1'b0}}};
      end
    end else if (busy_r) begin
      if (op_r == OP_DIV) begin
        acc_nxt = ge ? {{(DIST_BITS-COORD_BITS-1){1'b0}}, diff[COORD_BITS:0]}
                     : {{(DIST_BITS-COORD_BITS-1){1'b0}}, pa[COORD_BITS:0]};
        aux_nxt = {aux_r[DIST_BITS-2:0], ge};
      end else begin
        if (ge) begin
          acc_nxt = diff[DIST_BITS-1:0];
          aux_nxt = (aux_r >> 1) + bit_r;
        end else begin
          aux_nxt = aux_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(ITER_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    aux_r <= aux_nxt;
    bit_r <= bit_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = aux_r[COORD_BITS-1:0];
  assign rsp.rem  = acc_r[COORD_BITS-1:0];

endmodule

// ===== rtl/periodic_cell_list_neighbor_search_unit.sv =====
// Top level of the periodic cell list neighbor search unit.
// Depends on pcl_pkg and pcl_iter (shared divide / square root unit).

// One command is in flight at a time; in_ready is high only between commands.
// Every modulo, cell binning and square root runs on one shared unit at one
// result bit per cycle. An insert runs a wrap and a binning division per axis.
// An occupancy count walks the particle list of its cell. A query runs the
// same wrap and binning setup, then scans the grid cells; each candidate
// particle takes three wrap divisions and three squarings, and each match a
// square root. Results leave through an output register; a query's last
// result leaves once the walk ends. The cell head table clears at reset
// through per-entry valid bits.
module periodic_cell_list_neighbor_search_unit import pcl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic [COORD_BITS-1:0] in_pos_z,
  input  logic [COORD_BITS-1:0] in_search_radius,
  input  logic [CELL_BITS-1:0]  in_cell_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PART_BITS-1:0]  out_particle,
  output logic [CELL_BITS-1:0]  out_cell_id,
  output logic [CNT_BITS-1:0]   out_occupancy,
  output logic [COORD_BITS-1:0] out_distance,
  output logic                  out_found,
  output logic [1:0]            out_status,
  output logic                  out_last
);

  st_t state_r, state_nxt;

  logic [COORD_BITS-1:0] box_r, edge_r;
  logic [2:0]            cpa_r;
  logic [COORD_BITS:0]   box_eff, edge_eff;
  logic [2:0]            c_eff;
  logic [1:0]            cm1;
  logic [CNT_BITS-1:0]   c3;
  logic [3:0]            all_mask;

  logic [1:0]            cmd_r, cmd_nxt;
  logic [COORD_BITS-1:0] pos_r [3];
  logic [COORD_BITS-1:0] pos_nxt [3];
  logic [COORD_BITS-1:0] rad_r, rad_nxt;
  logic [COORD_BITS-1:0] w_r [3];
  logic [COORD_BITS-1:0] w_nxt [3];
  logic [1:0]            q_r [3];
  logic [1:0]            q_nxt [3];
  logic [3:0]            set_r [3];
  logic [3:0]            set_nxt [3];
  logic [1:0]            ax_r, ax_nxt;

  logic [CNT_BITS-1:0]   total_r, total_nxt;
  logic [CNT_BITS-1:0]   occ_r, occ_nxt;
  logic [PART_BITS-1:0]  p_r, p_nxt;
  logic [CELL_BITS-1:0]  hidx_r, hidx_nxt;
  logic [1:0]            ix_r, ix_nxt, iy_r, iy_nxt, iz_r, iz_nxt;
  logic                  visited_r, visited_nxt;

  logic [COORD_BITS-1:0] m_r, m_nxt;
  logic [COORD_BITS-1:0] mul_a;
  logic [DIST_BITS-1:0]  prod_r;
  logic [DIST_BITS-1:0]  d2_r, d2_nxt;
  logic [DIST_BITS-1:0]  r2_r, r2_nxt;

  res_t res_r, res_nxt, pend_r, pend_nxt, out_r;
  logic pend_vld_r, pend_vld_nxt, out_vld_r;

  logic [3*COORD_BITS-1:0] spos_mem [MAX_PARTICLES];
  logic [CNT_BITS-1:0]     link_mem [MAX_PARTICLES];
  logic [PART_BITS-1:0]    head_mem [CELL_SLOTS];
  logic [CELL_SLOTS-1:0]   hvalid_r;
  logic [3*COORD_BITS-1:0] spos_rd_r;
  logic [CNT_BITS-1:0]     link_rd_r;
  logic [PART_BITS-1:0]    head_rd_r;
  logic                    hv_rd_r;

  iter_req_t ireq;
  iter_rsp_t irsp;

  logic                  head_ok, link_ok, can_load, sel, scan_end, full, occ_bad;
  logic                  all_q;
  logic [CELL_BITS-1:0]  cell_ins, cell_scan;
  logic [COORD_BITS-1:0] spos_ax, dd, q_clamp;
  logic [COORD_BITS:0]   bm;

  pcl_iter u_iter (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ireq),
    .rsp  (irsp)
  );

  function automatic logic [CELL_BITS-1:0] cell_of(input logic [1:0] a, input logic [1:0] b,
                                                   input logic [1:0] c, input logic [2:0] n);
    logic [CNT_BITS-1:0] t;
    t = CNT_BITS'(CNT_BITS'(a) * CNT_BITS'(n)) + CNT_BITS'(b);
    t = CNT_BITS'(t * CNT_BITS'(n)) + CNT_BITS'(c);
    return t[CELL_BITS-1:0];
  endfunction

  function automatic logic [3:0] near_set(input logic [1:0] q);
    logic [1:0] lo, hi;
    lo = q - 2'd1;
    hi = q + 2'd1;
    return (4'd1 << q) | (4'd1 << lo) | (4'd1 << hi);
  endfunction

  // effective register values
  always_comb begin
    box_eff  = (box_r == '0) ? {1'b1, {COORD_BITS{1'b0}}} : {1'b0, box_r};
    edge_eff = (edge_r == '0) ? (COORD_BITS+1)'(1) : {1'b0, edge_r};
    if (cpa_r == 3'd0) c_eff = 3'd1;
    else if (cpa_r > 3'(MAX_CELLS)) c_eff = 3'(MAX_CELLS);
    else c_eff = cpa_r;
    cm1      = 2'(c_eff - 3'd1);
    c3       = CNT_BITS'(CNT_BITS'(c_eff) * CNT_BITS'(c_eff) * CNT_BITS'(c_eff));
    all_mask = 4'((5'd1 << c_eff) - 5'd1);
  end

  always_comb begin
    head_ok   = hv_rd_r && ({1'b0, head_rd_r} < total_r);
    link_ok   = link_rd_r < total_r;
    can_load  = !out_vld_r || out_ready;
    sel       = set_r[0][ix_r] && set_r[1][iy_r] && set_r[2][iz_r];
    scan_end  = (ix_r == cm1) && (iy_r == cm1) && (iz_r == cm1);
    full      = total_r >= CNT_BITS'(MAX_PARTICLES);
    occ_bad   = {1'b0, in_cell_index} >= c3;
    cell_ins  = cell_of(q_r[0], q_r[1], q_r[2], c_eff);
    cell_scan = cell_of(ix_r, iy_r, iz_r, c_eff);
    all_q     = ({rad_r, 1'b0} >= box_eff) || (c_eff != 3'(MAX_CELLS)) || (rad_r != '0);
    spos_ax   = spos_rd_r[ax_r*COORD_BITS +: COORD_BITS];
    q_clamp   = (irsp.quo > COORD_BITS'(cm1)) ? COORD_BITS'(cm1) : irsp.quo;
    dd        = (w_r[ax_r] > irsp.rem) ? w_r[ax_r] - irsp.rem : irsp.rem - w_r[ax_r];
    bm        = box_eff - {1'b0, dd};
    mul_a     = (state_r == S_DMUL) ? m_r : rad_r;
  end

  // shared unit requests
  always_comb begin
    ireq       = '0;
    ireq.op    = OP_DIV;
    ireq.dvs   = box_eff;
    case (state_r)
      S_WB_GO: begin
        ireq.start = 1'b1;
        ireq.opa   = DIST_BITS'(pos_r[ax_r]);
      end
      S_WE_GO: begin
        ireq.start = 1'b1;
        ireq.opa   = DIST_BITS'(w_r[ax_r]);
        ireq.dvs   = edge_eff;
      end
      S_DM_GO: begin
        ireq.start = 1'b1;
        ireq.opa   = DIST_BITS'(spos_ax);
      end
      S_SQ_GO: begin
        ireq.start = 1'b1;
        ireq.op    = OP_SQRT;
        ireq.opa   = d2_r;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_INSERT, CMD_QUERY: state_nxt = S_WB_GO;
            CMD_OCCUPY:            state_nxt = occ_bad ? S_EMIT : S_OCC_HEAD;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_OCC_HEAD: state_nxt = head_ok ? S_OCC_LINK : S_EMIT;
      S_OCC_LINK: state_nxt = link_ok ? S_OCC_LINK : S_EMIT;
      S_WB_GO:    state_nxt = S_WB_WAIT;
      S_WB_WAIT:  if (irsp.done) state_nxt = S_WE_GO;
      S_WE_GO:    state_nxt = S_WE_WAIT;
      S_WE_WAIT:  if (irsp.done) state_nxt = (ax_r == 2'd2) ? S_CELL : S_WB_GO;
      S_CELL: begin
        if (cmd_r == CMD_INSERT) state_nxt = full ? S_EMIT : S_INS_WR;
        else state_nxt = S_R2;
      end
      S_INS_WR:   state_nxt = S_EMIT;
      S_R2:       state_nxt = S_SCAN;
      S_SCAN: begin
        if (sel && !visited_r) state_nxt = S_HEAD;
        else if (scan_end) state_nxt = S_FLUSH;
      end
      S_HEAD:     state_nxt = head_ok ? S_PART : S_SCAN;
      S_PART:     state_nxt = S_DM_GO;
      S_DM_GO:    state_nxt = S_DM_WAIT;
      S_DM_WAIT:  if (irsp.done) state_nxt = S_DMUL;
      S_DMUL:     state_nxt = S_DACC;
      S_DACC:     state_nxt = (ax_r == 2'd2) ? S_DCMP : S_DM_GO;
      S_DCMP:     state_nxt = (d2_r <= r2_r) ? S_SQ_GO : S_NEXTP;
      S_SQ_GO:    state_nxt = S_SQ_WAIT;
      S_SQ_WAIT:  if (irsp.done) state_nxt = S_PUSH;
      S_PUSH:     if (!pend_vld_r || can_load) state_nxt = S_NEXTP;
      S_NEXTP:    state_nxt = link_ok ? S_PART : S_SCAN;
      S_FLUSH:    state_nxt = S_EMIT;
      S_EMIT:     if (can_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    cmd_nxt      = cmd_r;
    pos_nxt      = pos_r;
    rad_nxt      = rad_r;
    w_nxt        = w_r;
    q_nxt        = q_r;
    set_nxt      = set_r;
    ax_nxt       = ax_r;
    total_nxt    = total_r;
    occ_nxt      = occ_r;
    p_nxt        = p_r;
    hidx_nxt     = hidx_r;
    ix_nxt       = ix_r;
    iy_nxt       = iy_r;
    iz_nxt       = iz_r;
    visited_nxt  = visited_r;
    m_nxt        = m_r;
    d2_nxt       = d2_r;
    r2_nxt       = r2_r;
    res_nxt      = res_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          pos_nxt[0] = in_pos_x;
          pos_nxt[1] = in_pos_y;
          pos_nxt[2] = in_pos_z;
          rad_nxt    = in_search_radius;
          ax_nxt     = 2'd0;
          occ_nxt    = '0;
          hidx_nxt   = in_cell_index;
          res_nxt        = '0;
          res_nxt.status = STAT_RANGE;
          res_nxt.last   = 1'b1;
        end
      end
      S_OCC_HEAD: begin
        if (head_ok) begin
          occ_nxt = CNT_BITS'(1);
          p_nxt   = head_rd_r;
        end else begin
          res_nxt      = '0;
          res_nxt.last = 1'b1;
        end
      end
      S_OCC_LINK: begin
        if (link_ok) begin
          occ_nxt = occ_r + CNT_BITS'(1);
          p_nxt   = link_rd_r[PART_BITS-1:0];
        end else begin
          res_nxt           = '0;
          res_nxt.occupancy = occ_r;
          res_nxt.last      = 1'b1;
        end
      end
      S_WB_WAIT: if (irsp.done) w_nxt[ax_r] = irsp.rem;
      S_WE_WAIT: begin
        if (irsp.done) begin
          q_nxt[ax_r] = q_clamp[1:0];
          if (ax_r != 2'd2) ax_nxt = ax_r + 2'd1;
        end
      end
      S_CELL: begin
        hidx_nxt        = cell_ins;
        res_nxt         = '0;
        res_nxt.cell_id = cell_ins;
        res_nxt.status  = STAT_FULL;
        res_nxt.last    = 1'b1;
        for (int a = 0; a < 3; a++) set_nxt[a] = all_q ? all_mask : near_set(q_r[a]);
      end
      S_INS_WR: begin
        total_nxt        = total_r + CNT_BITS'(1);
        res_nxt          = '0;
        res_nxt.particle = total_r[PART_BITS-1:0];
        res_nxt.cell_id  = hidx_r;
        res_nxt.last     = 1'b1;
      end
      S_R2: begin
        r2_nxt      = prod_r;
        ix_nxt      = 2'd0;
        iy_nxt      = 2'd0;
        iz_nxt      = 2'd0;
        visited_nxt = 1'b0;
      end
      S_SCAN: begin
        if (sel && !visited_r) begin
          visited_nxt = 1'b1;
          hidx_nxt    = cell_scan;
        end else begin
          visited_nxt = 1'b0;
          if (iz_r != cm1) iz_nxt = iz_r + 2'd1;
          else begin
            iz_nxt = 2'd0;
            if (iy_r != cm1) iy_nxt = iy_r + 2'd1;
            else begin
              iy_nxt = 2'd0;
              if (ix_r != cm1) ix_nxt = ix_r + 2'd1;
            end
          end
        end
      end
      S_HEAD: begin
        if (head_ok) begin
          p_nxt  = head_rd_r;
          d2_nxt = '0;
          ax_nxt = 2'd0;
        end
      end
      S_DM_WAIT: begin
        if (irsp.done) m_nxt = (bm < {1'b0, dd}) ? bm[COORD_BITS-1:0] : dd;
      end
      S_DACC: begin
        d2_nxt = d2_r + prod_r;
        if (ax_r != 2'd2) ax_nxt = ax_r + 2'd1;
      end
      S_SQ_WAIT: begin
        if (irsp.done) begin
          res_nxt          = '0;
          res_nxt.particle = p_r;
          res_nxt.distance = irsp.quo;
          res_nxt.found    = 1'b1;
        end
      end
      S_PUSH: begin
        if (!pend_vld_r || can_load) begin
          pend_nxt     = res_r;
          pend_vld_nxt = 1'b1;
        end
      end
      S_NEXTP: begin
        if (link_ok) begin
          p_nxt  = link_rd_r[PART_BITS-1:0];
          d2_nxt = '0;
          ax_nxt = 2'd0;
        end
      end
      S_FLUSH: begin
        // hold-back register lets the final match carry the last flag
        if (pend_vld_r) res_nxt = pend_r;
        else res_nxt = '0;
        res_nxt.last = 1'b1;
        pend_vld_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      box_r      <= {COORD_BITS{1'b1}};
      cpa_r      <= 3'd1;
      edge_r     <= {COORD_BITS{1'b1}};
      total_r    <= '0;
      hvalid_r   <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      total_r    <= total_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_BOX:   box_r  <= cfg_wdata;
          REG_CELLS: cpa_r  <= cfg_wdata[2:0];
          REG_EDGE:  edge_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_INS_WR) hvalid_r[hidx_r] <= 1'b1;
      if (state_r == S_PUSH && pend_vld_r && can_load) out_vld_r <= 1'b1;
      else if (state_r == S_EMIT && can_load) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
    if (state_r == S_PUSH && pend_vld_r && can_load) out_r <= pend_r;
    else if (state_r == S_EMIT && can_load) out_r <= res_r;
    cmd_r     <= cmd_nxt;
    pos_r     <= pos_nxt;
    rad_r     <= rad_nxt;
    w_r       <= w_nxt;
    q_r       <= q_nxt;
    set_r     <= set_nxt;
    ax_r      <= ax_nxt;
    occ_r     <= occ_nxt;
    p_r       <= p_nxt;
    hidx_r    <= hidx_nxt;
    ix_r      <= ix_nxt;
    iy_r      <= iy_nxt;
    iz_r      <= iz_nxt;
    visited_r <= visited_nxt;
    m_r       <= m_nxt;
    d2_r      <= d2_nxt;
    r2_r      <= r2_nxt;
    res_r     <= res_nxt;
    pend_r    <= pend_nxt;
    prod_r    <= DIST_BITS'(mul_a) * DIST_BITS'(mul_a);
  end

  // particle store, link list and cell heads
  always_ff @(posedge clk) begin
    if (state_r == S_INS_WR) begin
      spos_mem[total_r[PART_BITS-1:0]] <= {pos_r[2], pos_r[1], pos_r[0]};
      link_mem[total_r[PART_BITS-1:0]] <= head_ok ? {1'b0, head_rd_r}
                                                  : CNT_BITS'(MAX_PARTICLES);
      head_mem[hidx_r] <= total_r[PART_BITS-1:0];
    end
    spos_rd_r <= spos_mem[p_nxt];
    link_rd_r <= link_mem[p_nxt];
    head_rd_r <= head_mem[hidx_nxt];
    hv_rd_r   <= hvalid_r[hidx_nxt];
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_vld_r;
  assign out_particle  = out_r.particle;
  assign out_cell_id   = out_r.cell_id;
  assign out_occupancy = out_r.occupancy;
  assign out_distance  = out_r.distance;
  assign out_found     = out_r.found;
  assign out_status    = out_r.status;
  assign out_last      = out_r.last;

endmodule

// ===== bench/tb_periodic_cell_list_neighbor_search_unit.sv =====
// Self-checking bench for periodic_cell_list_neighbor_search_unit: inserts,
// occupancy counts and radius queries checked against an in-bench predictor.
// Depends on pcl_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_periodic_cell_list_neighbor_search_unit;
  import pcl_pkg::*;

  typedef struct {
    logic [1:0]            cmd;
    logic [COORD_BITS-1:0] x, y, z, radius;
    logic [CELL_BITS-1:0]  cidx;
  } cmd_item_t;

  logic                  clk, rst_n;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [COORD_BITS-1:0] cfg_wdata;
  logic                  in_valid, in_ready;
  logic [1:0]            in_command;
  logic [COORD_BITS-1:0] in_pos_x, in_pos_y, in_pos_z, in_search_radius;
  logic [CELL_BITS-1:0]  in_cell_index;
  logic                  out_valid, out_ready;
  logic [PART_BITS-1:0]  out_particle;
  logic [CELL_BITS-1:0]  out_cell_id;
  logic [CNT_BITS-1:0]   out_occupancy;
  logic [COORD_BITS-1:0] out_distance;
  logic                  out_found;
  logic [1:0]            out_status;
  logic                  out_last;

  periodic_cell_list_neighbor_search_unit dut (.*);

  // predictor state
  logic [COORD_BITS-1:0] box_reg, edge_reg;
  logic [2:0]            cells_reg;
  logic [COORD_BITS-1:0] part_pos [MAX_PARTICLES][3];
  logic [CNT_BITS-1:0]   head_of [CELL_SLOTS];
  logic [CNT_BITS-1:0]   link_of [MAX_PARTICLES];
  int unsigned           stored_cnt;

  cmd_item_t pending_q [$];
  res_t      answer_q [$];
  int        mismatches, n_insert, n_occupy, n_query, n_results;

  function automatic void queue_item(cmd_item_t it);
    pending_q.insert(pending_q.size(), it);
  endfunction

  function automatic void queue_answer(res_t r);
    answer_q.insert(answer_q.size(), r);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #300_000_000;
    $display("Timeout waiting for the unit to drain");
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] box_eff();
    return (box_reg == 0) ? 64'd1 << COORD_BITS : 64'(box_reg);
  endfunction

  function automatic logic [63:0] cells_eff();
    if (cells_reg == 0) return 1;
    if (cells_reg > MAX_CELLS) return MAX_CELLS;
    return 64'(cells_reg);
  endfunction

  function automatic logic [63:0] edge_eff();
    return (edge_reg == 0) ? 64'd1 : 64'(edge_reg);
  endfunction

  function automatic logic [63:0] bin_of(logic [63:0] w);
    logic [63:0] q;
    q = w / edge_eff();
    return (q > cells_eff() - 1) ? cells_eff() - 1 : q;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // candidate cells along one axis, as a bit mask
  function automatic logic [3:0] axis_mask(logic [63:0] w, logic [63:0] r);
    logic [63:0] c, ctr, reach;
    logic [3:0]  m;
    c = cells_eff();
    m = 0;
    if (2 * r >= box_eff()) return 4'((64'd1 << c) - 1);
    ctr = bin_of(w);
    reach = (r + edge_eff() - 1) / edge_eff() + 1;
    if (reach >= c / 2) return 4'((64'd1 << c) - 1);
    for (logic [63:0] k = 0; k <= 2 * reach; k++)
      m[(ctr + c * reach + k - reach) % c] = 1'b1;
    return m;
  endfunction

  function automatic logic [63:0] wrap_gap(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = (a > b) ? a - b : b - a;
    return (box_eff() - d < d) ? box_eff() - d : d;
  endfunction

  function automatic res_t blank_res();
    res_t r;
    r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic compute_answers(input cmd_item_t it);
    logic [63:0] w [3];
    logic [63:0] c, cell_no, r2, d2, rad;
    logic [3:0]  mx, my, mz;
    int unsigned p, steps, hits;
    res_t        res;
    c = cells_eff();
    rad = 64'(it.radius);
    w[0] = 64'(it.x) % box_eff();
    w[1] = 64'(it.y) % box_eff();
    w[2] = 64'(it.z) % box_eff();
    res = blank_res();
    case (it.cmd)
      CMD_INSERT: begin
        n_insert++;
        cell_no = (bin_of(w[0]) * c + bin_of(w[1])) * c + bin_of(w[2]);
        res.cell_id = cell_no[CELL_BITS-1:0];
        if (stored_cnt >= MAX_PARTICLES) begin
          res.status = STAT_FULL;
        end else begin
          part_pos[stored_cnt][0] = it.x;
          part_pos[stored_cnt][1] = it.y;
          part_pos[stored_cnt][2] = it.z;
          link_of[stored_cnt] = head_of[cell_no];
          head_of[cell_no] = CNT_BITS'(stored_cnt);
          res.particle = PART_BITS'(stored_cnt);
          stored_cnt++;
        end
        queue_answer(res);
      end
      CMD_OCCUPY: begin
        n_occupy++;
        if (64'(it.cidx) >= c * c * c) begin
          res.status = STAT_RANGE;
        end else begin
          p = head_of[it.cidx];
          steps = 0;
          while (p < stored_cnt && steps < MAX_PARTICLES) begin
            steps++;
            p = link_of[p];
          end
          res.occupancy = CNT_BITS'(steps);
        end
        queue_answer(res);
      end
      CMD_QUERY: begin
        n_query++;
        mx = axis_mask(w[0], rad);
        my = axis_mask(w[1], rad);
        mz = axis_mask(w[2], rad);
        r2 = rad * rad;
        hits = 0;
        for (int ix = 0; ix < c; ix++)
          for (int iy = 0; iy < c; iy++)
            for (int iz = 0; iz < c; iz++) begin
              if (!(mx[ix] && my[iy] && mz[iz])) continue;
              p = head_of[(ix * c + iy) * c + iz];
              steps = 0;
              while (p < stored_cnt && steps < MAX_PARTICLES && hits < MAX_PARTICLES) begin
                d2 = 0;
                for (int a = 0; a < 3; a++)
                  d2 += wrap_gap(w[a], 64'(part_pos[p][a]) % box_eff()) ** 2;
                if (d2 <= r2) begin
                  res = '0;
                  res.particle = PART_BITS'(p);
                  res.distance = COORD_BITS'(root_floor(d2));
                  res.found = 1'b1;
                  queue_answer(res);
                  hits++;
                end
                steps++;
                p = link_of[p];
              end
            end
        if (hits == 0) queue_answer(blank_res());
        else answer_q[$].last = 1'b1;
      end
      default: ;  // unused code: no answer
    endcase
  endtask

  // driver: bursts of transactions separated by random gaps
  int gap_left, burst_left;
  always @(posedge clk) begin : drive_in
    cmd_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 4;
    end else begin
      if (in_valid && in_ready) begin
        it.cmd = in_command;
        it.x = in_pos_x;
        it.y = in_pos_y;
        it.z = in_pos_z;
        it.radius = in_search_radius;
        it.cidx = in_cell_index;
        compute_answers(it);
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          in_valid <= 1'b1;
          in_command <= it.cmd;
          in_pos_x <= it.x;
          in_pos_y <= it.y;
          in_pos_z <= it.z;
          in_search_radius <= it.radius;
          in_cell_index <= it.cidx;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_mode, mode_cnt;
  always @(posedge clk) begin : watch_out
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
      mode_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result transaction: particle %0d", out_particle);
        end else begin
          want = answer_q.pop_front();
          if (out_particle !== want.particle || out_cell_id !== want.cell_id ||
              out_occupancy !== want.occupancy || out_distance !== want.distance ||
              out_found !== want.found || out_status !== want.status ||
              out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: exp p=%0d c=%0d o=%0d d=%0d f=%0d s=%0d l=%0d",
                        " / got p=%0d c=%0d o=%0d d=%0d f=%0d s=%0d l=%0d"},
                       want.particle, want.cell_id, want.occupancy, want.distance,
                       want.found, want.status, want.last, out_particle, out_cell_id,
                       out_occupancy, out_distance, out_found, out_status, out_last);
          end
        end
      end
      mode_cnt <= mode_cnt + 1;
      if (mode_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= (mode_cnt % 3 != 0);
        2: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic cmd_item_t make_item(logic [1:0] cmd, logic [COORD_BITS-1:0] x,
                                          logic [COORD_BITS-1:0] y, logic [COORD_BITS-1:0] z,
                                          logic [COORD_BITS-1:0] r, logic [CELL_BITS-1:0] cidx);
    cmd_item_t it;
    it.cmd = cmd;
    it.x = x;
    it.y = y;
    it.z = z;
    it.radius = r;
    it.cidx = cidx;
    return it;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return COORD_BITS'($urandom);
    return COORD_BITS'($urandom_range(0, 32'(box_eff() - 1)));
  endfunction

  function automatic cmd_item_t rand_item();
    cmd_item_t   it;
    int unsigned pick, p;
    logic [63:0] eb;
    eb = box_eff();
    pick = $urandom_range(0, 99);
    it = make_item(CMD_INSERT, rand_coord(), rand_coord(), rand_coord(),
                   COORD_BITS'($urandom), CELL_BITS'($urandom));
    if (pick < 35) return it;
    if (pick < 58) begin
      it.cmd = CMD_OCCUPY;
      if ($urandom_range(0, 3) != 0)
        it.cidx = CELL_BITS'($urandom_range(0, 32'(cells_eff() ** 3 - 1)));
      return it;
    end
    if (pick < 95) begin
      it.cmd = CMD_QUERY;
      case ($urandom_range(0, 3))
        0: it.radius = 0;
        1: it.radius = COORD_BITS'($urandom_range(0, 32'(eb / 8)));
        2: it.radius = COORD_BITS'($urandom_range(0, 32'(eb / 2)));
        default: ;
      endcase
      // center near a stored particle most of the time
      if (stored_cnt > 0 && $urandom_range(0, 2) != 0) begin
        p = $urandom_range(0, stored_cnt - 1);
        it.x = part_pos[p][0] + COORD_BITS'($urandom_range(0, 32'(it.radius) / 2));
        it.y = part_pos[p][1] - COORD_BITS'($urandom_range(0, 32'(it.radius) / 2));
        it.z = part_pos[p][2];
      end
      return it;
    end
    it.cmd = 2'd3;
    return it;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() > 0 || in_valid || answer_q.size() > 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [COORD_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BOX:   box_reg = val;
      REG_CELLS: cells_reg = val[2:0];
      default:   edge_reg = val;
    endcase
  endtask

  task automatic set_config(logic [COORD_BITS-1:0] box, logic [COORD_BITS-1:0] cells,
                            logic [COORD_BITS-1:0] edge_len, int n_rand);
    wait_drained();
    write_reg(REG_BOX, box);
    write_reg(REG_CELLS, cells);
    write_reg(REG_EDGE, edge_len);
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (n_rand) queue_item(rand_item());
  endtask

  localparam logic [COORD_BITS-1:0] CMAX = '1;

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_command = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_search_radius = '0;
    in_cell_index = '0;
    box_reg = CMAX;
    cells_reg = 3'd1;
    edge_reg = CMAX;
    stored_cnt = 0;
    foreach (head_of[i]) head_of[i] = MAX_PARTICLES;
    mismatches = 0;
    n_insert = 0;
    n_occupy = 0;
    n_query = 0;
    n_results = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: empty store, out-of-range cell, ignored code
    queue_item(make_item(CMD_QUERY, 0, 0, 0, 0, 0));
    queue_item(make_item(CMD_QUERY, CMAX, CMAX, CMAX, CMAX, CELL_BITS'('1)));
    queue_item(make_item(CMD_OCCUPY, 0, 0, 0, 0, 0));
    queue_item(make_item(CMD_OCCUPY, 0, 0, 0, 0, 63));
    queue_item(make_item(2'd3, CMAX, 0, CMAX, CMAX, 21));
    queue_item(make_item(CMD_INSERT, 0, 0, 0, 0, 0));
    queue_item(make_item(CMD_INSERT, CMAX, CMAX, CMAX, CMAX, 63));
    queue_item(make_item(CMD_QUERY, 1, 2, 3, CMAX, 0));
    queue_item(make_item(CMD_OCCUPY, 0, 0, 0, 0, 0));

    // 4x4x4 grid; positions past the box wrap around
    set_config(1000, 4, 250, 0);
    queue_item(make_item(CMD_INSERT, 999, 0, 500, 0, 0));
    queue_item(make_item(CMD_INSERT, 1500, 1250, 249, 0, 0));
    queue_item(make_item(CMD_INSERT, 10, 990, 3, 0, 0));
    queue_item(make_item(CMD_QUERY, 999, 0, 500, 0, 0));
    queue_item(make_item(CMD_QUERY, 5, 995, 998, 30, 0));
    queue_item(make_item(CMD_QUERY, 500, 500, 500, 0, 0));
    queue_item(make_item(CMD_OCCUPY, 0, 0, 0, 0, 6'd50));
    queue_item(make_item(CMD_OCCUPY, 0, 0, 0, 0, 63));
    repeat (110) queue_item(rand_item());

    // zero box and zero edge
    set_config(0, 3, 0, 80);
    // zero cell count
    set_config(1, 0, CMAX, 50);
    // cell count above the maximum saturates
    set_config(4096, 7, 1024, 120);
    set_config(CMAX, 2, 24'h800000, 80);

    wait_drained();
    $display("Covered %0d inserts, %0d occupancy and %0d radius queries; %0d results checked",
             n_insert, n_occupy, n_query, n_results);
    $display("Register settings: 6 (box, cell count and edge extremes), %0d mismatches",
             mismatches);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
